// ===== src/dlle_pkg.sv =====
// ----------------------------------------------------------------------------
// dlle_pkg: shared types and codes of the doubly linked list engine
// Request modes, result status codes, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package dlle_pkg;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 3;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS    = 3'd0,
		MODE_DEL    = 3'd1,
		MODE_DFIRST = 3'd2,
		MODE_DLAST  = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 3'd0,
		ST_FULL  = 3'd1,
		ST_MISS  = 3'd2,
		ST_ELEM  = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ADR_HEAD,
		ADR_TAIL,
		ADR_NEXT
	} adr_sel_t;

	typedef struct packed {
		logic     rd_links;
		adr_sel_t adr;
		logic     rd_free;
		logic     latch_key;
		logic     alloc;
		logic     link;
		logic     unlink;
		logic     emit;
		logic     emit_elem;
		status_t  emit_status;
	} dlle_cmd_t;

	typedef struct packed {
		logic full;
		logic head_sent;
		logic tail_sent;
		logic next_sent;
		logic key_hit;
		logic out_free;
	} dlle_sts_t;

endpackage

// ===== src/dlle_if.sv =====
// ----------------------------------------------------------------------------
// dlle_if: request and result channels of the doubly linked list engine
// Valid/ready channels; a request or result moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface dlle_req_if;
	logic                               valid;
	logic                               ready;
	logic        [dlle_pkg::MODE_W-1:0] mode;
	logic signed [dlle_pkg::KEY_W-1:0]  key;

	modport source (output valid, mode, key, input ready);
	modport sink   (input valid, mode, key, output ready);
endinterface

interface dlle_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic        [dlle_pkg::STATUS_W-1:0] status;
	logic signed [dlle_pkg::KEY_W-1:0]    key_out;
	logic        [dlle_pkg::COUNT_W-1:0]  count;
	logic                                 last;

	modport source (output valid, status, key_out, count, last, input ready);
	modport sink   (input valid, status, key_out, count, last, output ready);
endinterface

// ===== src/dlle_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlle_ctrl: sequencer of the doubly linked list engine
// Takes one request at a time and steps the datapath through allocation,
// linking, list walks and unlinking, and issues each result.
// ----------------------------------------------------------------------------
module dlle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	dlle_req_if.sink            req,
	input  dlle_pkg::dlle_sts_t sts,
	output dlle_pkg::dlle_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_LINK,
		S_UNLINK,
		S_WALK,
		S_RESP
	} state_t;

	state_t              state_q, state_d;
	logic                read_q, read_d;
	dlle_pkg::status_t   resp_q, resp_d;

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		read_d  = read_q;
		resp_d  = resp_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd.latch_key = 1'b1;
					unique case (dlle_pkg::mode_t'(req.mode))
						dlle_pkg::MODE_INS: begin
							if (sts.full) begin
								resp_d  = dlle_pkg::ST_FULL;
								state_d = S_RESP;
							end else begin
								cmd.rd_free = 1'b1;
								state_d     = S_ALLOC;
							end
						end
						dlle_pkg::MODE_DEL: begin
							if (sts.head_sent) begin
								resp_d  = dlle_pkg::ST_MISS;
								state_d = S_RESP;
							end else begin
								cmd.rd_links = 1'b1;
								cmd.adr      = dlle_pkg::ADR_HEAD;
								read_d       = 1'b0;
								state_d      = S_WALK;
							end
						end
						dlle_pkg::MODE_DFIRST: begin
							if (sts.head_sent) begin
								resp_d  = dlle_pkg::ST_MISS;
								state_d = S_RESP;
							end else begin
								cmd.rd_links = 1'b1;
								cmd.adr      = dlle_pkg::ADR_HEAD;
								state_d      = S_UNLINK;
							end
						end
						dlle_pkg::MODE_DLAST: begin
							if (sts.tail_sent) begin
								resp_d  = dlle_pkg::ST_MISS;
								state_d = S_RESP;
							end else begin
								cmd.rd_links = 1'b1;
								cmd.adr      = dlle_pkg::ADR_TAIL;
								state_d      = S_UNLINK;
							end
						end
						dlle_pkg::MODE_READ: begin
							if (sts.head_sent) begin
								resp_d  = dlle_pkg::ST_EMPTY;
								state_d = S_RESP;
							end else begin
								cmd.rd_links = 1'b1;
								cmd.adr      = dlle_pkg::ADR_HEAD;
								read_d       = 1'b1;
								state_d      = S_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_LINK;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				resp_d   = dlle_pkg::ST_DONE;
				state_d  = S_RESP;
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				resp_d     = dlle_pkg::ST_DONE;
				state_d    = S_RESP;
			end
			S_WALK: begin
				if (read_q) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_elem   = 1'b1;
						cmd.emit_status = dlle_pkg::ST_ELEM;
						if (sts.next_sent) begin
							state_d = S_IDLE;
						end else begin
							cmd.rd_links = 1'b1;
							cmd.adr      = dlle_pkg::ADR_NEXT;
						end
					end
				end else if (sts.key_hit) begin
					cmd.unlink = 1'b1;
					resp_d     = dlle_pkg::ST_DONE;
					state_d    = S_RESP;
				end else if (sts.next_sent) begin
					resp_d  = dlle_pkg::ST_MISS;
					state_d = S_RESP;
				end else begin
					cmd.rd_links = 1'b1;
					cmd.adr      = dlle_pkg::ADR_NEXT;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = resp_q;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			read_q  <= 1'b0;
			resp_q  <= dlle_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			read_q  <= read_d;
			resp_q  <= resp_d;
		end
	end

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while output slot busy");

	a_mem_ops: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rd_links, cmd.rd_free, cmd.alloc, cmd.link, cmd.unlink}))
		else $error("conflicting memory operations");

	a_ins_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.mode == dlle_pkg::MODE_INS && !sts.full)
		|=> state_q == S_ALLOC)
		else $error("insert did not enter allocation");

endmodule

// ===== src/dlle_dp.sv =====
// ----------------------------------------------------------------------------
// dlle_dp: datapath of the doubly linked list engine
// Node key and link memories, free node stack, head/tail of the sentinel,
// key count and the result register.
// ----------------------------------------------------------------------------
module dlle_dp #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [dlle_pkg::KEY_W-1:0] key,
	input  dlle_pkg::dlle_cmd_t               cmd,
	output dlle_pkg::dlle_sts_t               sts,
	dlle_rsp_if.source                        rsp
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam logic [LINK_W-1:0] SENT = LINK_W'(CAPACITY);

	logic [KEY_BITS-1:0] key_mem  [CAPACITY];
	logic [LINK_W-1:0]   next_mem [CAPACITY];
	logic [LINK_W-1:0]   prev_mem [CAPACITY];
	logic [IDX_W-1:0]    free_mem [CAPACITY];

	logic [LINK_W-1:0]   head_q, tail_q, count_q, fill_q;
	logic [LINK_W-1:0]   cur_q, new_q, ohead_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] key_rd_q;
	logic [LINK_W-1:0]   next_rd_q, prev_rd_q;
	logic [IDX_W-1:0]    free_rd_q;

	logic                              out_valid_q;
	dlle_pkg::status_t                 out_status_q;
	logic [dlle_pkg::KEY_W-1:0]        out_key_q;
	logic [dlle_pkg::COUNT_W-1:0]      out_count_q;
	logic                              out_last_q;

	logic [LINK_W-1:0] rd_addr, pos, top, alloc_node;
	logic              fresh;
	logic              next_we, prev_we;
	logic [LINK_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

	always_comb begin
		unique case (cmd.adr)
			dlle_pkg::ADR_HEAD: rd_addr = head_q;
			dlle_pkg::ADR_TAIL: rd_addr = tail_q;
			dlle_pkg::ADR_NEXT: rd_addr = next_rd_q;
			default:            rd_addr = head_q;
		endcase
	end

	assign pos        = LINK_W'(CAPACITY - 1) - count_q;
	assign top        = SENT - count_q;
	assign fresh      = (pos < fill_q);
	assign alloc_node = fresh ? count_q : LINK_W'(free_rd_q);

	always_comb begin
		next_we = cmd.alloc || (cmd.unlink && prev_rd_q != SENT);
		next_wa = cmd.alloc ? alloc_node : prev_rd_q;
		next_wd = cmd.alloc ? head_q : next_rd_q;
	end

	always_comb begin
		prev_we = cmd.alloc || (cmd.link && ohead_q != SENT)
			|| (cmd.unlink && next_rd_q != SENT);
		priority if (cmd.alloc) begin
			prev_wa = alloc_node;
			prev_wd = SENT;
		end else if (cmd.link) begin
			prev_wa = ohead_q;
			prev_wd = new_q;
		end else begin
			prev_wa = next_rd_q;
			prev_wd = prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc)
			key_mem[alloc_node[IDX_W-1:0]] <= key_q;
		if (cmd.rd_links)
			key_rd_q <= key_mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa[IDX_W-1:0]] <= next_wd;
		if (cmd.rd_links)
			next_rd_q <= next_mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_wa[IDX_W-1:0]] <= prev_wd;
		if (cmd.rd_links)
			prev_rd_q <= prev_mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.unlink)
			free_mem[top[IDX_W-1:0]] <= cur_q[IDX_W-1:0];
		if (cmd.rd_free)
			free_rd_q <= free_mem[pos[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= SENT;
			tail_q      <= SENT;
			count_q     <= '0;
			fill_q      <= SENT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc) begin
				head_q  <= alloc_node;
				if (head_q == SENT)
					tail_q <= alloc_node;
				count_q <= count_q + 1'b1;
				if (fresh)
					fill_q <= pos;
			end else if (cmd.unlink) begin
				if (prev_rd_q == SENT)
					head_q <= next_rd_q;
				if (next_rd_q == SENT)
					tail_q <= prev_rd_q;
				count_q <= count_q - 1'b1;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_key)
			key_q <= KEY_BITS'(key);
		if (cmd.rd_links)
			cur_q <= rd_addr;
		if (cmd.alloc) begin
			new_q   <= alloc_node;
			ohead_q <= head_q;
		end
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_key_q    <= cmd.emit_elem ? dlle_pkg::KEY_W'(key_rd_q) : '0;
			out_count_q  <= dlle_pkg::COUNT_W'(count_q);
			out_last_q   <= cmd.emit_elem ? (next_rd_q == SENT) : 1'b1;
		end
	end

	assign sts.full      = (count_q == SENT);
	assign sts.head_sent = (head_q == SENT);
	assign sts.tail_sent = (tail_q == SENT);
	assign sts.next_sent = (next_rd_q == SENT);
	assign sts.key_hit   = (key_rd_q == key_q);
	assign sts.out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.key_out = out_key_q;
	assign rsp.count   = out_count_q;
	assign rsp.last    = out_last_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SENT)
		else $error("key count above capacity");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((head_q == SENT) == (count_q == '0)) && ((tail_q == SENT) == (count_q == '0)))
		else $error("head/tail disagree with key count");

	a_fill_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= top)
		else $error("free stack top below fill mark");

endmodule

// ===== src/doubly_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top: doubly linked list engine
// Keeps signed keys in a fixed node pool with a sentinel and a free stack;
// insert front, delete by key/first/last, and read-out front to back.
//
//   channel  dir  payload                         handshake
//   req      in   mode[3], key[32]                valid/ready
//   rsp      out  status[3], key_out[32],         valid/ready
//                 count[7], last
//
// One request at a time; req.ready is high only between requests.
// Insert reads the free stack, allocates and links; delete first/last reads the
// end node and unlinks it; delete by key and read-out walk one node per link read.
// Results leave through a one-deep output register; rsp stalls hold the walk.
// After reset the engine takes requests at once; no clearing pass.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_top #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	dlle_req_if.sink   req,
	dlle_rsp_if.source rsp
);

	dlle_pkg::dlle_cmd_t cmd;
	dlle_pkg::dlle_sts_t sts;

	dlle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd)
	);

	dlle_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (req.key),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
